// ----- rtl/core/redcode_instruction_executor_unit_defines.svh -----
// Assertion macros for the Redcode instruction executor.
`ifndef REDCODE_INSTRUCTION_EXECUTOR_UNIT_DEFINES_SVH
`define REDCODE_INSTRUCTION_EXECUTOR_UNIT_DEFINES_SVH
`define RIE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define RIE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ----- rtl/core/rie_pkg.sv -----
// Package with types and constants of the Redcode instruction executor.
`default_nettype none
package rie_pkg;
    localparam int CoreSize = 8192;
    localparam int AddrW = $clog2(CoreSize);
    localparam int OwnW = 4;
    localparam int CellW = 4 + 2 + 2 + AddrW + AddrW + OwnW;

    localparam logic [1:0] CMD_EXEC = 2'd0;
    localparam logic [1:0] CMD_LOAD = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    localparam logic [1:0] MODE_IMM = 2'd0;
    localparam logic [1:0] MODE_DIR = 2'd1;
    localparam logic [1:0] MODE_IND = 2'd2;

    localparam logic [3:0] OP_DAT = 4'd0;
    localparam logic [3:0] OP_MOV = 4'd1;
    localparam logic [3:0] OP_ADD = 4'd2;
    localparam logic [3:0] OP_SUB = 4'd3;
    localparam logic [3:0] OP_JMP = 4'd4;
    localparam logic [3:0] OP_JMZ = 4'd5;
    localparam logic [3:0] OP_JMN = 4'd6;
    localparam logic [3:0] OP_DJN = 4'd7;
    localparam logic [3:0] OP_CMP = 4'd8;
    localparam logic [3:0] OP_SPL = 4'd9;

    typedef logic [AddrW-1:0] t_addr;

    typedef struct packed {
        logic [3:0] op;
        logic [1:0] ma;
        logic [1:0] mb;
        t_addr      fa;
        t_addr      fb;
        logic [OwnW-1:0] own;
    } t_cell;

    typedef enum logic [3:0] {
        S_IDLE, S_CLEAR, S_FETCH, S_PTR_A, S_PTR_B, S_RD_A, S_RD_B,
        S_EXEC, S_DONE
    } t_state;

    typedef struct packed {
        logic  we;
        t_addr waddr;
        t_cell wdata;
        t_addr raddr;
    } t_mem_req;
endpackage
`default_nettype wire

// ----- rtl/core/rie_core_mem.sv -----
// Core memory of 8192 cells with one write port and one registered read port.
`default_nettype none
module rie_core_mem import rie_pkg::*; (
    input  wire logic     i_clk,
    input  wire t_mem_req i_req,
    output t_cell         o_rdata
);
    t_cell r_mem [CoreSize];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        o_rdata <= r_mem[i_req.raddr];
    end
endmodule
`default_nettype wire

// ----- rtl/core/rie_ctrl.sv -----
// Sequencer: clear, load, read, or fetch operands, execute and write back.
`default_nettype none
module rie_ctrl import rie_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [1:0]  i_cmd,
    input  wire t_addr       i_address,
    input  wire logic [3:0]  i_warrior_id,
    input  wire logic [3:0]  i_load_opcode,
    input  wire logic [1:0]  i_load_mode_a,
    input  wire logic [1:0]  i_load_mode_b,
    input  wire t_addr       i_load_field_a,
    input  wire t_addr       i_load_field_b,
    input  wire t_cell       i_rdata,
    output t_mem_req         o_req,
    output logic             o_busy,
    output logic             o_done,
    output t_addr            o_next_pc,
    output logic             o_spawn_valid,
    output t_addr            o_spawn_pc,
    output logic             o_kill,
    output logic             o_fault,
    output t_cell            o_cell
);
    t_state r_state, n_state;
    t_addr  r_clr, n_clr;
    logic [1:0] r_cmd;
    t_addr  r_pc, r_ta, r_tb, n_ta, n_tb;
    logic [3:0] r_own;
    t_cell  r_ld, r_ins, r_ca, r_cb, n_ins, n_ca, n_cb;
    logic   r_done;
    t_addr  r_next_pc, r_spawn_pc, n_next_pc, n_spawn_pc;
    logic   r_spv, r_kill, r_fault, n_spv, n_kill, n_fault;
    t_cell  r_cell, n_cell;
    logic   n_done;
    logic   a_ok, b_ok, a_addr, b_addr, need_a, need_b;
    t_addr  pa, pb, va, vb;
    t_cell  wcell;
    logic   wen;
    t_addr  wad, dec;
    logic   take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr <= '0;
            r_done <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr <= n_clr;
            r_done <= n_done;
        end
        if (r_state == S_IDLE && i_start) begin
            r_cmd <= i_cmd;
            r_pc <= i_address;
            r_own <= i_warrior_id;
            r_ld <= '{op: i_load_opcode, ma: i_load_mode_a, mb: i_load_mode_b,
                      fa: i_load_field_a, fb: i_load_field_b, own: i_warrior_id};
        end
        r_ins <= n_ins;
        r_ca <= n_ca;
        r_cb <= n_cb;
        r_ta <= n_ta;
        r_tb <= n_tb;
        r_next_pc <= n_next_pc;
        r_spawn_pc <= n_spawn_pc;
        r_spv <= n_spv;
        r_kill <= n_kill;
        r_fault <= n_fault;
        r_cell <= n_cell;
    end

    always_comb begin
        pa = r_pc + r_ins.fa;
        pb = r_pc + r_ins.fb;
        a_addr = (r_ins.ma == MODE_DIR) || (r_ins.ma == MODE_IND);
        b_addr = (r_ins.mb == MODE_DIR) || (r_ins.mb == MODE_IND);
        a_ok = a_addr || (r_ins.ma == MODE_IMM);
        b_ok = b_addr || (r_ins.mb == MODE_IMM);
        va = (r_ins.ma == MODE_IMM) ? r_ins.fa : r_ca.fb;
        vb = (r_ins.mb == MODE_IMM) ? r_ins.fb : r_cb.fb;
        need_a = a_addr;
        need_b = b_addr;
        dec = r_cb.fb - t_addr'(1);
        take = (r_ins.op == OP_JMZ) ? (vb == '0) : (vb != '0);
    end

    always_comb begin
        n_state = r_state;
        n_clr = r_clr;
        case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + t_addr'(1);
                if (r_clr == t_addr'(CoreSize - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_state = (i_cmd == CMD_EXEC) ? S_FETCH : S_DONE;
                end
            end
            S_FETCH: n_state = S_PTR_A;
            S_PTR_A: n_state = S_PTR_B;
            S_PTR_B: n_state = S_RD_A;
            S_RD_A:  n_state = S_RD_B;
            S_RD_B:  n_state = S_EXEC;
            S_EXEC:  n_state = S_DONE;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_ins = r_ins;
        n_ca = r_ca;
        n_cb = r_cb;
        n_ta = r_ta;
        n_tb = r_tb;
        n_next_pc = r_next_pc;
        n_spawn_pc = r_spawn_pc;
        n_spv = r_spv;
        n_kill = r_kill;
        n_fault = r_fault;
        n_cell = r_cell;
        n_done = 1'b0;
        wen = 1'b0;
        wad = r_pc;
        wcell = r_ld;
        o_req.raddr = r_pc;
        case (r_state)
            S_CLEAR: begin
                wen = 1'b1;
                wad = r_clr;
                wcell = '0;
            end
            S_IDLE: begin
                o_req.raddr = i_address;
            end
            S_FETCH: begin
                n_ins = i_rdata;
            end
            S_PTR_A: begin
                o_req.raddr = pa;
            end
            S_PTR_B: begin
                n_ta = (r_ins.ma == MODE_IND) ? pa + i_rdata.fb : pa;
                o_req.raddr = pb;
            end
            S_RD_A: begin
                n_tb = (r_ins.mb == MODE_IND) ? pb + i_rdata.fb : pb;
                o_req.raddr = r_ta;
            end
            S_RD_B: begin
                n_ca = i_rdata;
                o_req.raddr = r_tb;
            end
            S_EXEC: begin
                n_cb = i_rdata;
            end
            S_DONE: begin
                n_done = 1'b1;
                n_next_pc = '0;
                n_spawn_pc = '0;
                n_spv = 1'b0;
                n_kill = 1'b0;
                n_fault = 1'b0;
                n_cell = '0;
                if (r_cmd == CMD_LOAD) begin
                    wen = 1'b1;
                    wcell = r_ld;
                    n_cell = r_ld;
                end else if (r_cmd == CMD_READ) begin
                    n_cell = i_rdata;
                end else if (r_cmd == CMD_EXEC) begin
                    n_next_pc = r_pc + t_addr'(1);
                    wad = r_tb;
                    case (r_ins.op)
                        OP_DAT: begin
                            n_kill = 1'b1;
                            n_next_pc = r_pc;
                        end
                        OP_MOV: begin
                            if (!a_ok || !need_b) begin
                                n_fault = 1'b1;
                            end else begin
                                wen = 1'b1;
                                wcell = (r_ins.ma == MODE_IMM) ?
                                    t_cell'{op: OP_DAT, ma: MODE_IMM, mb: MODE_IMM, fa: '0,
                                            fb: r_ins.fa, own: r_own} : r_ca;
                                wcell.own = r_own;
                            end
                        end
                        OP_ADD, OP_SUB: begin
                            if (!a_ok || !need_b) begin
                                n_fault = 1'b1;
                            end else begin
                                wen = 1'b1;
                                wcell = r_cb;
                                wcell.fb = (r_ins.op == OP_ADD) ? r_cb.fb + va
                                                                : r_cb.fb - va;
                                wcell.own = r_own;
                            end
                        end
                        OP_JMP: begin
                            if (!need_b) n_fault = 1'b1;
                            else n_next_pc = r_tb;
                        end
                        OP_JMZ, OP_JMN: begin
                            if (!b_ok) begin
                                n_fault = 1'b1;
                            end else if (take) begin
                                if (!need_a) n_fault = 1'b1;
                                else n_next_pc = r_ta;
                            end
                        end
                        OP_DJN: begin
                            if (!need_b || (dec != '0 && !need_a)) begin
                                n_fault = 1'b1;
                            end else begin
                                wen = 1'b1;
                                wcell = r_cb;
                                wcell.fb = dec;
                                wcell.own = r_own;
                                if (dec != '0) begin
                                    if (r_ins.ma == MODE_IND && pa == r_tb) begin
                                        n_next_pc = pa + dec;
                                    end else begin
                                        n_next_pc = r_ta;
                                    end
                                end
                            end
                        end
                        OP_CMP: begin
                            if (!a_ok || !b_ok) n_fault = 1'b1;
                            else if (va == vb) n_next_pc = r_pc + t_addr'(2);
                        end
                        OP_SPL: begin
                            if (!need_b) begin
                                n_fault = 1'b1;
                            end else begin
                                n_spv = 1'b1;
                                n_spawn_pc = r_tb;
                            end
                        end
                        default: n_fault = 1'b1;
                    endcase
                    if (n_fault) begin
                        wen = 1'b0;
                        n_next_pc = r_pc;
                        n_kill = 1'b0;
                        n_spv = 1'b0;
                        n_spawn_pc = '0;
                    end
                end
            end
            default: ;
        endcase
        o_req.we = wen;
        o_req.waddr = wad;
        o_req.wdata = wcell;
    end

    always_comb begin
        o_busy = (r_state != S_IDLE);
        o_done = r_done;
        o_next_pc = r_next_pc;
        o_spawn_valid = r_spv;
        o_spawn_pc = r_spawn_pc;
        o_kill = r_kill;
        o_fault = r_fault;
        o_cell = r_cell;
    end
endmodule
`default_nettype wire

// ----- rtl/core/redcode_instruction_executor_unit.sv -----
// Top level of the Redcode instruction executor.
// After reset the core is cleared, one cell a cycle for all 8192 cells, while busy is high.
// An execute request passes through fetch, two pointer reads and two operand reads, all through
// the single read port of the core memory, then write back; a load or read request goes
// straight to the done state. Busy is low during the strobe cycle, so the next request can be
// accepted at the edge that ends it. The result is shown for exactly one cycle on o_done and
// cannot be stalled by the receiver.
`default_nettype none
`include "redcode_instruction_executor_unit_defines.svh"
module redcode_instruction_executor_unit import rie_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [1:0] i_cmd,
    input  wire logic [12:0] i_address,
    input  wire logic [3:0] i_warrior_id,
    input  wire logic [3:0] i_load_opcode,
    input  wire logic [1:0] i_load_mode_a,
    input  wire logic [1:0] i_load_mode_b,
    input  wire logic [12:0] i_load_field_a,
    input  wire logic [12:0] i_load_field_b,
    output logic            o_done,
    output logic [12:0]     o_next_pc,
    output logic            o_spawn_valid,
    output logic [12:0]     o_spawn_pc,
    output logic            o_kill,
    output logic            o_fault,
    output logic [3:0]      o_cell_opcode,
    output logic [1:0]      o_cell_mode_a,
    output logic [1:0]      o_cell_mode_b,
    output logic [12:0]     o_cell_field_a,
    output logic [12:0]     o_cell_field_b,
    output logic [3:0]      o_cell_owner
);
    t_mem_req req;
    t_cell    rdata, res_cell;

    rie_core_mem u_mem (.i_clk(i_clk), .i_req(req), .o_rdata(rdata));

    rie_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_cmd(i_cmd),
        .i_address(i_address), .i_warrior_id(i_warrior_id),
        .i_load_opcode(i_load_opcode), .i_load_mode_a(i_load_mode_a),
        .i_load_mode_b(i_load_mode_b), .i_load_field_a(i_load_field_a),
        .i_load_field_b(i_load_field_b), .i_rdata(rdata), .o_req(req),
        .o_busy(busy), .o_done(o_done), .o_next_pc(o_next_pc),
        .o_spawn_valid(o_spawn_valid), .o_spawn_pc(o_spawn_pc), .o_kill(o_kill),
        .o_fault(o_fault), .o_cell(res_cell)
    );

    assign o_cell_opcode = res_cell.op;
    assign o_cell_mode_a = res_cell.ma;
    assign o_cell_mode_b = res_cell.mb;
    assign o_cell_field_a = res_cell.fa;
    assign o_cell_field_b = res_cell.fb;
    assign o_cell_owner = res_cell.own;

    `RIE_ASSERT_IMPL(a_done_idle, i_clk, i_rst_n, o_done, !$past(o_done), "double strobe")
    `RIE_ASSERT_IMPL(a_spawn_zero, i_clk, i_rst_n, o_done && !o_spawn_valid, o_spawn_pc == '0, "spawn")
    `RIE_ASSERT_IMPL(a_fault_clean, i_clk, i_rst_n, o_done && o_fault, !o_kill && !o_spawn_valid, "flags")
    `RIE_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy, "start not taken")
endmodule
`default_nettype wire

// ----- tb/redcode_instruction_executor_unit_tb.sv -----
// Testbench for the Redcode instruction executor: directed table plus random core programs.
`timescale 1ns / 100ps
module redcode_instruction_executor_unit_tb;
    import rie_pkg::*;

    localparam int WatchLimit = 40000;
    localparam int RandomRequests = 1530;

    typedef struct {
        logic [3:0]  op;
        logic [1:0]  ma;
        logic [1:0]  mb;
        logic [12:0] fa;
        logic [12:0] fb;
        logic [3:0]  own;
    } t_ref_cell;

    typedef struct {
        logic [12:0] next_pc;
        logic        spawn_valid;
        logic [12:0] spawn_pc;
        logic        kill;
        logic        fault;
        logic [3:0]  op;
        logic [1:0]  ma;
        logic [1:0]  mb;
        logic [12:0] fa;
        logic [12:0] fb;
        logic [3:0]  own;
    } t_outcome;

    typedef struct {
        logic [1:0]  cmd;
        logic [12:0] addr;
        logic [3:0]  wid;
        logic [3:0]  op;
        logic [1:0]  ma;
        logic [1:0]  mb;
        logic [12:0] fa;
        logic [12:0] fb;
        logic        has_known;
        t_outcome    known;
    } t_request;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    logic [1:0] i_cmd;
    logic [12:0] i_address;
    logic [3:0] i_warrior_id;
    logic [3:0] i_load_opcode;
    logic [1:0] i_load_mode_a;
    logic [1:0] i_load_mode_b;
    logic [12:0] i_load_field_a;
    logic [12:0] i_load_field_b;
    logic o_done;
    logic [12:0] o_next_pc;
    logic o_spawn_valid;
    logic [12:0] o_spawn_pc;
    logic o_kill;
    logic o_fault;
    logic [3:0] o_cell_opcode;
    logic [1:0] o_cell_mode_a;
    logic [1:0] o_cell_mode_b;
    logic [12:0] o_cell_field_a;
    logic [12:0] o_cell_field_b;
    logic [3:0] o_cell_owner;

    redcode_instruction_executor_unit dut (.*);

    t_ref_cell core_copy [0:8191];
    t_outcome pending_outcomes[$];
    int errors = 0;
    int idle_cycles = 0;
    int sender_gap_pct = 0;
    bit timed_out = 0;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit find_addr(input logic [12:0] pc, input logic [1:0] mode,
                                     input logic [12:0] field, output logic [12:0] addr);
        logic [12:0] p;
        p = pc + field;
        addr = 0;
        if (mode == MODE_DIR) begin
            addr = p;
            return 1;
        end
        if (mode == MODE_IND) begin
            addr = p + core_copy[p].fb;
            return 1;
        end
        return 0;
    endfunction

    function automatic bit find_value(input logic [12:0] pc, input logic [1:0] mode,
                                      input logic [12:0] field, output logic [12:0] val);
        logic [12:0] a;
        val = 0;
        if (mode == MODE_IMM) begin
            val = field;
            return 1;
        end
        if (!find_addr(pc, mode, field, a)) return 0;
        val = core_copy[a].fb;
        return 1;
    endfunction

    function automatic t_outcome run_instruction(input logic [12:0] pc, input logic [3:0] wid);
        t_outcome r;
        t_ref_cell c;
        t_ref_cell moved;
        logic [12:0] ta, tb, v1, v2, nv;
        bit ok;
        bit take;
        r = '{default: 0};
        c = core_copy[pc];
        ok = 1;
        r.next_pc = pc + 13'd1;
        ta = 0;
        tb = 0;
        case (c.op)
            OP_DAT: begin
                r.kill = 1;
                r.next_pc = pc;
            end
            OP_MOV: begin
                if (c.ma == MODE_IMM) moved = '{OP_DAT, MODE_IMM, MODE_IMM, 13'd0, c.fa, 4'd0};
                else if (find_addr(pc, c.ma, c.fa, ta)) moved = core_copy[ta];
                else ok = 0;
                if (ok && !find_addr(pc, c.mb, c.fb, tb)) ok = 0;
                if (ok) begin
                    moved.own = wid;
                    core_copy[tb] = moved;
                end
            end
            OP_ADD, OP_SUB: begin
                if (!find_value(pc, c.ma, c.fa, v1)) ok = 0;
                else if (!find_addr(pc, c.mb, c.fb, tb)) ok = 0;
                else begin
                    if (c.op == OP_ADD) core_copy[tb].fb = core_copy[tb].fb + v1;
                    else core_copy[tb].fb = core_copy[tb].fb - v1;
                    core_copy[tb].own = wid;
                end
            end
            OP_JMP: begin
                if (!find_addr(pc, c.mb, c.fb, tb)) ok = 0;
                else r.next_pc = tb;
            end
            OP_JMZ, OP_JMN: begin
                if (!find_value(pc, c.mb, c.fb, v2)) ok = 0;
                else begin
                    take = (c.op == OP_JMZ) ? (v2 == 0) : (v2 != 0);
                    if (take) begin
                        if (!find_addr(pc, c.ma, c.fa, ta)) ok = 0;
                        else r.next_pc = ta;
                    end
                end
            end
            OP_DJN: begin
                if (!find_addr(pc, c.mb, c.fb, tb)) ok = 0;
                else begin
                    nv = core_copy[tb].fb - 13'd1;
                    if (nv != 0 && c.ma != MODE_DIR && c.ma != MODE_IND) ok = 0;
                    else begin
                        core_copy[tb].fb = nv;
                        core_copy[tb].own = wid;
                        if (nv != 0) begin
                            void'(find_addr(pc, c.ma, c.fa, ta));
                            r.next_pc = ta;
                        end
                    end
                end
            end
            OP_CMP: begin
                if (!find_value(pc, c.ma, c.fa, v1)) ok = 0;
                else if (!find_value(pc, c.mb, c.fb, v2)) ok = 0;
                else if (v1 == v2) r.next_pc = pc + 13'd2;
            end
            OP_SPL: begin
                if (!find_addr(pc, c.mb, c.fb, tb)) ok = 0;
                else begin
                    r.spawn_valid = 1;
                    r.spawn_pc = tb;
                end
            end
            default: ok = 0;
        endcase
        if (!ok) begin
            r.next_pc = pc;
            r.kill = 0;
            r.spawn_valid = 0;
            r.spawn_pc = 0;
            r.fault = 1;
        end
        return r;
    endfunction

    function automatic t_outcome predict_request(input t_request q);
        t_outcome r;
        t_ref_cell c;
        r = '{default: 0};
        if (q.cmd == CMD_EXEC) return run_instruction(q.addr, q.wid);
        if (q.cmd != CMD_LOAD && q.cmd != CMD_READ) return r;
        if (q.cmd == CMD_LOAD) core_copy[q.addr] = '{q.op, q.ma, q.mb, q.fa, q.fb, q.wid};
        c = core_copy[q.addr];
        r.op = c.op;
        r.ma = c.ma;
        r.mb = c.mb;
        r.fa = c.fa;
        r.fb = c.fb;
        r.own = c.own;
        return r;
    endfunction

    task automatic send_request(input t_request q);
        t_outcome r;
        while ($urandom_range(99) < sender_gap_pct) @(negedge i_clk);
        r = predict_request(q);
        if (q.has_known && r != q.known) begin
            $display("%0t: table entry differs, expected %p, actual %p", $time, q.known, r);
            errors++;
        end
        pending_outcomes.push_back(r);
        start = 1;
        i_cmd = q.cmd;
        i_address = q.addr;
        i_warrior_id = q.wid;
        i_load_opcode = q.op;
        i_load_mode_a = q.ma;
        i_load_mode_b = q.mb;
        i_load_field_a = q.fa;
        i_load_field_b = q.fb;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
        start = 0;
    endtask

    function automatic t_request make_request(input logic [1:0] cmd, input logic [12:0] addr,
            input logic [3:0] wid, input logic [3:0] op, input logic [1:0] ma,
            input logic [1:0] mb, input logic [12:0] fa, input logic [12:0] fb);
        t_request q;
        q = '{cmd, addr, wid, op, ma, mb, fa, fb, 1'b0, '{default: 0}};
        return q;
    endfunction

    function automatic t_outcome cell_outcome(input logic [3:0] op, input logic [1:0] ma,
            input logic [1:0] mb, input logic [12:0] fa, input logic [12:0] fb,
            input logic [3:0] own);
        t_outcome r;
        r = '{default: 0};
        r.op = op;
        r.ma = ma;
        r.mb = mb;
        r.fa = fa;
        r.fb = fb;
        r.own = own;
        return r;
    endfunction

    function automatic t_outcome exec_outcome(input logic [12:0] pc, input logic kill,
                                              input logic fault);
        t_outcome r;
        r = '{default: 0};
        r.next_pc = pc;
        r.kill = kill;
        r.fault = fault;
        return r;
    endfunction

    // Checks the one-cycle result strobe against the oldest prediction.
    always @(posedge i_clk) begin
        t_outcome got, want;
        if (i_rst_n && o_done) begin
            got = '{o_next_pc, o_spawn_valid, o_spawn_pc, o_kill, o_fault, o_cell_opcode,
                    o_cell_mode_a, o_cell_mode_b, o_cell_field_a, o_cell_field_b,
                    o_cell_owner};
            if (pending_outcomes.size() == 0) begin
                $display("%0t: unexpected result, actual %p", $time, got);
                errors++;
            end else begin
                want = pending_outcomes.pop_front();
                if (got != want) begin
                    $display("%0t: result differs, expected %p, actual %p", $time, want, got);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchLimit && !timed_out) begin
            timed_out = 1;
            $display("redcode_instruction_executor_unit: mismatch");
            $finish;
        end
    end

    initial begin
        t_request table_rows[$];
        t_request q;
        logic [12:0] base;
        int n;
        int k;
        int phase;
        for (int i = 0; i < 8192; i++) core_copy[i] = '{0, 0, 0, 0, 0, 0};
        start = 0;
        i_cmd = CMD_READ;
        i_address = 0;
        i_warrior_id = 0;
        i_load_opcode = 0;
        i_load_mode_a = 0;
        i_load_mode_b = 0;
        i_load_field_a = 0;
        i_load_field_b = 0;
        i_rst_n = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        q = make_request(CMD_READ, 13'd8191, 0, 0, 0, 0, 0, 0);
        q.has_known = 1;
        q.known = cell_outcome(OP_DAT, MODE_IMM, MODE_IMM, 0, 0, 0);
        table_rows.push_back(q);
        q = make_request(CMD_EXEC, 13'd0, 4'd3, 0, 0, 0, 0, 0);
        q.has_known = 1;
        q.known = exec_outcome(13'd0, 1, 0);
        table_rows.push_back(q);
        q = make_request(CMD_LOAD, 13'd8191, 4'd15, 4'd15, 2'd3, 2'd3, 13'd8191, 13'd8191);
        q.has_known = 1;
        q.known = cell_outcome(4'd15, 2'd3, 2'd3, 13'd8191, 13'd8191, 4'd15);
        table_rows.push_back(q);
        q = make_request(CMD_EXEC, 13'd8191, 4'd1, 0, 0, 0, 0, 0);
        q.has_known = 1;
        q.known = exec_outcome(13'd8191, 0, 1);
        table_rows.push_back(q);
        q = make_request(2'd3, 13'd5, 4'd2, 4'd1, 2'd1, 2'd1, 13'd1, 13'd1);
        q.has_known = 1;
        q.known = '{default: 0};
        table_rows.push_back(q);
        // A small program at 100 holding each opcode and mode; cells 100 to 109 are executed and cell 110 is read back.
        table_rows.push_back(make_request(CMD_LOAD, 13'd100, 1, OP_MOV, MODE_IMM, MODE_DIR, 7, 10));
        table_rows.push_back(make_request(CMD_LOAD, 13'd101, 1, OP_ADD, MODE_DIR, MODE_IND, 9, 11));
        table_rows.push_back(make_request(CMD_LOAD, 13'd102, 1, OP_SUB, MODE_IMM, MODE_DIR, 3, 8));
        table_rows.push_back(make_request(CMD_LOAD, 13'd103, 1, OP_JMP, MODE_IMM, MODE_IND, 0, 7));
        table_rows.push_back(make_request(CMD_LOAD, 13'd104, 1, OP_JMZ, MODE_IMM, MODE_IMM, 4, 0));
        table_rows.push_back(make_request(CMD_LOAD, 13'd105, 1, OP_JMN, MODE_DIR, MODE_IMM, 8190, 5));
        table_rows.push_back(make_request(CMD_LOAD, 13'd106, 1, OP_DJN, MODE_IND, MODE_DIR, 4, 4));
        table_rows.push_back(make_request(CMD_LOAD, 13'd107, 1, OP_CMP, MODE_IMM, MODE_IND, 0, 3));
        table_rows.push_back(make_request(CMD_LOAD, 13'd108, 1, OP_SPL, MODE_IMM, MODE_DIR, 0, 8100));
        table_rows.push_back(make_request(CMD_LOAD, 13'd109, 1, OP_DJN, MODE_IMM, MODE_DIR, 0, 1));
        table_rows.push_back(make_request(CMD_LOAD, 13'd110, 1, OP_DAT, MODE_IMM, MODE_IMM, 0, 1));
        for (int i = 100; i < 110; i++)
            table_rows.push_back(make_request(CMD_EXEC, 13'(i), 4'(i), 0, 0, 0, 0, 0));
        table_rows.push_back(make_request(CMD_READ, 13'd110, 0, 0, 0, 0, 0, 0));
        foreach (table_rows[i]) send_request(table_rows[i]);

        for (phase = 0; phase < 4; phase++) begin
            sender_gap_pct = (phase == 0) ? 0 : (phase == 2) ? 0 : (phase == 1) ? 49 : 13;
            n = 0;
            while (n < RandomRequests / 4) begin
                if ($urandom_range(9) < 8) begin
                    // Well-formed program: a few legal cells, then executions inside it.
                    base = 13'($urandom_range(8191));
                    k = $urandom_range(1, 4);
                    for (int j = 0; j < k; j++) begin
                        q = make_request(CMD_LOAD, base + 13'(j), 4'($urandom_range(15)),
                                4'($urandom_range(9)), 2'($urandom_range(2)),
                                2'($urandom_range(2)),
                                ($urandom_range(3) == 0) ? 13'($urandom_range(8191))
                                                         : 13'($urandom_range(6)),
                                ($urandom_range(3) == 0) ? 13'($urandom_range(8191))
                                                         : 13'($urandom_range(6)));
                        send_request(q);
                        n++;
                    end
                    for (int j = 0; j < k; j++) begin
                        send_request(make_request(CMD_EXEC, base + 13'($urandom_range(k - 1)),
                                4'($urandom_range(15)), 0, 0, 0, 0, 0));
                        n++;
                    end
                end else begin
                    q = make_request(2'($urandom_range(3)), 13'($urandom_range(8191)),
                            4'($urandom_range(15)), 4'($urandom_range(15)),
                            2'($urandom_range(3)), 2'($urandom_range(3)),
                            13'($urandom_range(8191)), 13'($urandom_range(8191)));
                    send_request(q);
                    n++;
                end
            end
        end

        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("redcode_instruction_executor_unit: match");
        end else begin
            $display("redcode_instruction_executor_unit: mismatch");
        end
        $finish;
    end
endmodule

// ----- redcode_instruction_executor_unit.f -----
+incdir+rtl/core
rtl/core/rie_pkg.sv
rtl/core/rie_core_mem.sv
rtl/core/rie_ctrl.sv
rtl/core/redcode_instruction_executor_unit.sv
tb/redcode_instruction_executor_unit_tb.sv
